// File: rtl/max_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// max_priority_queue_macros
// Assertion macros used by the priority queue top level.
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_MACROS_SVH
`define MAX_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define MPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and constants of the sorted-list max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PRIO_W      = 16;
  localparam int TAG_W       = 16;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;

  typedef logic [REQ_W-1:0]    req_code_t;
  typedef logic [STATUS_W-1:0] status_code_t;

  localparam req_code_t REQ_INSERT = 2'd0;
  localparam req_code_t REQ_REMOVE = 2'd1;
  localparam req_code_t REQ_PEEK   = 2'd2;

  localparam status_code_t STAT_OK    = 2'd0;
  localparam status_code_t STAT_FULL  = 2'd1;
  localparam status_code_t STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_HEAD,
    ST_SHIFT,
    ST_DONE
  } mpq_state_t;

  typedef struct packed {
    logic capture;
    logic ins_step;
    logic ins_put;
    logic head_rd;
    logic head_cap;
    logic shift_step;
    logic count_dec;
    logic res_load;
  } mpq_cmd_t;

  typedef struct packed {
    req_code_t        req;
    logic             full;
    logic             empty;
    logic             count_one;
    logic             k_one;
    logic             more_shift;
    logic             less;
    logic             out_busy;
    logic [CNT_W-1:0] count;
  } mpq_stat_t;

endpackage

// File: rtl/max_priority_queue.sv
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded priority queue kept as a sorted slot array, highest priority first.
// ----------------------------------------------------------------------------
// Input beats on in_*: in_tuser carries the request (insert, remove, peek),
// in_tdata the priority (unsigned Q8.8) and tag. Every input beat yields
// exactly one result beat on out_*: found and status in out_tuser, the tag
// and the occupancy after the operation in out_tdata.
// One request is processed at a time; in_tready is high only while idle.
// Inserts walk past the entries of lower priority and removes shift the
// remaining entries up; a full insert, an empty read or code 3 needs no
// walk, and a peek of a non-empty queue reads only the head. Each walk
// moves one slot per cycle through a single write port with a registered
// read.
// The result sits in an output register; a new request is accepted while it
// waits, and the sequencer holds its finished result until out_tready.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "max_priority_queue_macros.svh"

module max_priority_queue
  import mpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // priority_req[15:0], tag[31:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_tag[15:0], occupancy[20:16], zero pad
  output logic [2:0]  out_tuser   // found[0], status[2:1]
);

  mpq_cmd_t           cmd;
  mpq_stat_t          st;
  logic               found;
  logic [TAG_W-1:0]   out_tag;
  status_code_t       status;
  logic [OCC_W-1:0]   occupancy;

  mpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mpq_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .req_type     (in_tuser),
    .priority_req (in_tdata[15:0]),
    .tag          (in_tdata[31:16]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .found        (found),
    .out_tag      (out_tag),
    .status       (status),
    .occupancy    (occupancy)
  );

  assign out_tdata = {3'b000, occupancy, out_tag};
  assign out_tuser = {status, found};

  `MPQ_ASSERT_NOW(a_count_bound, 1'b1, st.count <= CNT_W'(QUEUE_DEPTH), "entry count over depth")
  `MPQ_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `MPQ_ASSERT_NOW(a_found_ok, out_tvalid && found, status == STAT_OK, "found with bad status")
  `MPQ_ASSERT_NOW(a_empty_tag, out_tvalid && !found, out_tag == '0, "tag without entry")

endmodule

// File: rtl/mpq_datapath.sv
// ----------------------------------------------------------------------------
// mpq_datapath
// Slot memory, walk counter, entry count and result register.
// ----------------------------------------------------------------------------
module mpq_datapath
  import mpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mpq_cmd_t          cmd,
  output mpq_stat_t         st,
  input  req_code_t         req_type,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic [TAG_W-1:0]  tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic [TAG_W-1:0]  out_tag,
  output status_code_t      status,
  output logic [OCC_W-1:0]  occupancy
);

  entry_t             mem [QUEUE_DEPTH];
  entry_t             rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;

  req_code_t          req_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [TAG_W-1:0]   tag_r;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   km1, km2, kp1;
  logic               res_found_r;
  status_code_t       res_status_r;
  logic [TAG_W-1:0]   head_tag_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [TAG_W-1:0]   out_tag_r;
  status_code_t       out_status_r;
  logic [OCC_W-1:0]   out_occ_r;

  assign km1 = k_r - CNT_W'(1);
  assign km2 = k_r - CNT_W'(2);
  assign kp1 = k_r + CNT_W'(1);

  always_comb begin
    k_nxt = k_r;
    if (cmd.capture) begin
      k_nxt = count_r;
    end else if (cmd.ins_step) begin
      k_nxt = km1;
    end else if (cmd.head_cap) begin
      k_nxt = CNT_W'(1);
    end else if (cmd.shift_step) begin
      k_nxt = kp1;
    end
  end

  always_comb begin
    rd_addr = km1[ADDR_W-1:0];
    if (cmd.ins_step) begin
      rd_addr = km2[ADDR_W-1:0];
    end else if (cmd.head_rd) begin
      rd_addr = '0;
    end else if (cmd.head_cap) begin
      rd_addr = ADDR_W'(1);
    end else if (cmd.shift_step) begin
      rd_addr = kp1[ADDR_W-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k_r[ADDR_W-1:0];
    wr_data = rd_data_r;
    if (cmd.ins_step) begin
      wr_en = 1'b1;
    end else if (cmd.ins_put) begin
      wr_en   = 1'b1;
      wr_data = '{tag: tag_r, prio: prio_r};
    end else if (cmd.shift_step) begin
      wr_en   = 1'b1;
      wr_addr = km1[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_put) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.count_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (cmd.capture) begin
      req_r       <= req_type;
      prio_r      <= priority_req;
      tag_r       <= tag;
      head_tag_r  <= '0;
      res_found_r <= 1'b0;
      res_status_r <= STAT_OK;
      if (req_type == REQ_INSERT && count_r == CNT_W'(QUEUE_DEPTH)) begin
        res_status_r <= STAT_FULL;
      end else if (req_type == REQ_REMOVE || req_type == REQ_PEEK) begin
        if (count_r == '0) begin
          res_status_r <= STAT_EMPTY;
        end else begin
          res_found_r <= 1'b1;
        end
      end
    end
    if (cmd.head_cap) begin
      head_tag_r <= rd_data_r.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_found_r  <= res_found_r;
      out_tag_r    <= head_tag_r;
      out_status_r <= res_status_r;
      out_occ_r    <= OCC_W'(count_r);
    end
  end

  assign st.req        = req_r;
  assign st.full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign st.empty      = (count_r == '0);
  assign st.count_one  = (count_r == CNT_W'(1));
  assign st.k_one      = (k_r == CNT_W'(1));
  assign st.more_shift = (kp1 < count_r);
  assign st.less       = (rd_data_r.prio < prio_r);
  assign st.out_busy   = out_valid_r && !out_ready;
  assign st.count      = count_r;

  assign out_valid = out_valid_r;
  assign found     = out_found_r;
  assign out_tag   = out_tag_r;
  assign status    = out_status_r;
  assign occupancy = out_occ_r;

endmodule

// File: rtl/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer for insert walk, head read, shift-up and result hand-off.
// ----------------------------------------------------------------------------
module mpq_ctrl
  import mpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mpq_stat_t st,
  output mpq_cmd_t  cmd
);

  mpq_state_t state_r, state_nxt;
  logic       is_read;

  assign is_read = (st.req == REQ_REMOVE) || (st.req == REQ_PEEK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (st.req == REQ_INSERT && !st.full) begin
          state_nxt = st.empty ? ST_INS_PUT : ST_INS_CMP;
        end else if (is_read && !st.empty) begin
          state_nxt = ST_HEAD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_INS_CMP: begin
        if (!st.less) begin
          state_nxt = ST_DONE;
        end else if (st.k_one) begin
          state_nxt = ST_INS_PUT;
        end
      end
      ST_INS_PUT: state_nxt = ST_DONE;
      ST_HEAD: begin
        if (st.req == REQ_REMOVE && !st.count_one) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (!st.more_shift) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!st.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        cmd.head_rd = is_read && !st.empty;
      end
      ST_INS_CMP: begin
        cmd.ins_step = st.less;
        cmd.ins_put  = !st.less;
      end
      ST_INS_PUT: cmd.ins_put = 1'b1;
      ST_HEAD: begin
        cmd.head_cap  = 1'b1;
        cmd.count_dec = (st.req == REQ_REMOVE) && st.count_one;
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.count_dec  = !st.more_shift;
      end
      ST_DONE: cmd.res_load = !st.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted-list max priority queue.
// ----------------------------------------------------------------------------
// A queue of requests (insert, remove, peek, unused code) drives in_* under
// random valid gaps, and random backpressure is applied on out_*. Each
// accepted request runs through an in-bench sorted slot model. The model
// predicts found, tag, status and occupancy, and each result beat is
// compared with the oldest prediction. The directed opening covers:
//   - empty reads
//   - the extreme priorities and tags
//   - FIFO order among equal priorities
//   - a full queue and a dropped insert
// Random traffic then mixes randomly chosen fill-heavy, drain-heavy and balanced runs.
// ----------------------------------------------------------------------------
module testbench
  import mpq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam req_code_t REQ_UNUSED = 2'd3;
  localparam int        RAND_ITEMS = 900;

  typedef struct {
    req_code_t   req;
    logic [15:0] prio;
    logic [15:0] tag;
    bit          drain_first;  // hold until all results are back
    bit          steady;       // no idling on either side
  } request_t;

  typedef struct {
    logic         found;
    logic [15:0]  tag;
    status_code_t status;
    logic [4:0]   occ;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // priority_req[15:0], tag[31:16]
  logic [1:0]  in_tuser = '0;    // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // out_tag[15:0], occupancy[20:16], zero pad
  logic [2:0]  out_tuser;        // found[0], status[2:1]

  request_t    pending_reqs[$];
  request_t    cur_req;
  outcome_t    due_results[$];
  bit          steady_now = 1'b0;
  int          err_count = 0;

  // queue model
  logic [15:0] prio_slots[QUEUE_DEPTH];
  logic [15:0] tag_slots[QUEUE_DEPTH];
  int          held_count = 0;

  int n_insert = 0, n_remove = 0, n_peek = 0, n_unused = 0;
  int n_dropped = 0, n_empty_reads = 0, peak_occ = 0, n_checked = 0;

  max_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void apply_request(request_t r);
    outcome_t res;
    int pos;
    res = '{found: 1'b0, tag: 16'h0, status: STAT_OK, occ: 5'd0};
    case (r.req)
      REQ_INSERT: begin
        n_insert++;
        if (held_count >= QUEUE_DEPTH) begin
          res.status = STAT_FULL;
          n_dropped++;
        end else begin
          pos = 0;
          while (pos < held_count && prio_slots[pos] >= r.prio) pos++;
          for (int k = held_count; k > pos; k--) begin
            prio_slots[k] = prio_slots[k-1];
            tag_slots[k]  = tag_slots[k-1];
          end
          prio_slots[pos] = r.prio;
          tag_slots[pos]  = r.tag;
          held_count++;
          if (held_count > peak_occ) peak_occ = held_count;
        end
      end
      REQ_REMOVE, REQ_PEEK: begin
        if (r.req == REQ_REMOVE) n_remove++;
        else n_peek++;
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
          n_empty_reads++;
        end else begin
          res.found = 1'b1;
          res.tag   = tag_slots[0];
          if (r.req == REQ_REMOVE) begin
            for (int k = 1; k < held_count; k++) begin
              prio_slots[k-1] = prio_slots[k];
              tag_slots[k-1]  = tag_slots[k];
            end
            held_count--;
          end
        end
      end
      default: n_unused++;
    endcase
    res.occ = 5'(held_count);
    due_results.push_back(res);
  endfunction

  // driver
  always @(posedge clk) begin : drive_blk
    bit go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_request(cur_req);
      if (!in_tvalid || in_tready) begin
        go = 1'b0;
        if (pending_reqs.size() > 0) begin
          steady_now = pending_reqs[0].steady;
          if (pending_reqs[0].drain_first &&
              (due_results.size() > 0 || (in_tvalid && in_tready)))
            go = 1'b0;
          else
            go = steady_now || ($urandom_range(99) >= 15);
        end
        if (go) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_req.tag, cur_req.prio};
          in_tuser  <= cur_req.req;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_blk
    outcome_t want;
    logic         got_found;
    logic [15:0]  got_tag;
    status_code_t got_status;
    logic [4:0]   got_occ;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_tag    = out_tdata[15:0];
        got_occ    = out_tdata[20:16];
        got_found  = out_tuser[0];
        got_status = out_tuser[2:1];
        if (due_results.size() == 0) begin
          $error("unexpected result beat: tag %h occupancy %0d", got_tag, got_occ);
          err_count++;
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (got_found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, got_found);
            err_count++;
          end
          if (got_tag !== want.tag) begin
            $error("out_tag: expected %h, got %h", want.tag, got_tag);
            err_count++;
          end
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            err_count++;
          end
          if (got_occ !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, got_occ);
            err_count++;
          end
        end
      end
      out_tready <= steady_now || ($urandom_range(99) >= 15);
    end
  end

  // stimulus
  function automatic void add_req(req_code_t req, logic [15:0] prio, logic [15:0] tag,
                                  bit drain_first = 1'b0, bit steady = 1'b0);
    request_t r;
    r.req = req;
    r.prio = prio;
    r.tag = tag;
    r.drain_first = drain_first;
    r.steady = steady;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [15:0] pick_prio();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    if (r < 40) begin
      case ($urandom_range(2))
        0: return 16'h0100;
        1: return 16'h0180;
        default: return 16'h8000;
      endcase
    end
    return 16'($urandom());
  endfunction

  initial begin
    int mode, run_len, r, idx;
    req_code_t rq;

    // empty queue
    add_req(REQ_PEEK, 16'h1234, 16'h5678);
    add_req(REQ_REMOVE, 16'h0, 16'h0);
    add_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    // extremes and ties
    add_req(REQ_INSERT, 16'h0000, 16'h0000);
    add_req(REQ_INSERT, 16'hFFFF, 16'hFFFF);
    add_req(REQ_INSERT, 16'h0100, 16'hA5A5);
    add_req(REQ_INSERT, 16'h0100, 16'h5A5A);
    add_req(REQ_PEEK, 16'h0, 16'h0);
    add_req(REQ_UNUSED, 16'h0, 16'h0);
    add_req(REQ_REMOVE, 16'h0, 16'h0);
    add_req(REQ_REMOVE, 16'h0, 16'h0);
    add_req(REQ_REMOVE, 16'h0, 16'h0);
    // fill to the top, then overflow
    for (int k = 0; k < QUEUE_DEPTH - 1; k++)
      add_req(REQ_INSERT, (k % 3 == 0) ? 16'h0100 : 16'(k * 16'h1111), 16'(16'hC000 + k));
    add_req(REQ_INSERT, 16'hFFFF, 16'hDEAD);
    add_req(REQ_PEEK, 16'h0, 16'h0, 1'b1);

    idx = 0;
    while (idx < RAND_ITEMS) begin
      mode = $urandom_range(2);
      run_len = $urandom_range(10, 60);
      for (int j = 0; j < run_len && idx < RAND_ITEMS; j++) begin
        r = $urandom_range(99);
        case (mode)
          0: rq = (r < 75) ? REQ_INSERT : (r < 88) ? REQ_REMOVE :
                  (r < 97) ? REQ_PEEK : REQ_UNUSED;
          1: rq = (r < 20) ? REQ_INSERT : (r < 80) ? REQ_REMOVE :
                  (r < 96) ? REQ_PEEK : REQ_UNUSED;
          default: rq = (r < 45) ? REQ_INSERT : (r < 85) ? REQ_REMOVE :
                        (r < 97) ? REQ_PEEK : REQ_UNUSED;
        endcase
        add_req(rq, pick_prio(), 16'($urandom()), (idx % 150 == 149),
                (idx >= 400 && idx < 560));
        idx++;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 8) @(posedge clk);

    $display("Checked %0d results: %0d inserts (%0d dropped when full), %0d removes, %0d peeks",
             n_checked, n_insert, n_dropped, n_remove, n_peek);
    $display("%0d unused-code requests, %0d reads of an empty queue, peak occupancy %0d",
             n_unused, n_empty_reads, peak_occ);
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mpq_pkg.sv
rtl/mpq_datapath.sv
rtl/mpq_ctrl.sv
rtl/max_priority_queue.sv
tb/testbench.sv
